>>> src/tfe_pkg.sv
// Package: shared types and constants of the dual HD44780 text front end.
`default_nettype none
package tfe_pkg;

	localparam int TFE_QUEUE_DEPTH = 4;

	localparam logic [7:0] CELL_END    = 8'd160;
	localparam logic [7:0] LINE1_START = 8'd40;
	localparam logic [7:0] LOWER_START = 8'd80;
	localparam logic [7:0] LINE3_START = 8'd120;
	localparam logic [7:0] LINE2_START = 8'd80;
	localparam logic [7:0] LAST_UPPER  = 8'd79;
	localparam logic [7:0] LINE1_OFFS  = 8'd24;
	localparam logic [7:0] LINE2_OFFS  = 8'd80;
	localparam logic [7:0] LINE3_OFFS  = 8'd56;
	localparam logic [5:0] LAST_COLUMN = 6'd39;

	localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
	localparam logic [7:0] CMD_LINE_ODD   = 8'hC0;
	localparam logic [7:0] CMD_SET_CGRAM  = 8'h40;
	localparam logic [7:0] CMD_FUNCTION   = 8'h38;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_HOME       = 8'h02;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;

	localparam logic [1:0] WAIT_SHORT = 2'd0;
	localparam logic [1:0] WAIT_LONG  = 2'd1;
	localparam logic [1:0] WAIT_DATA  = 2'd2;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	localparam logic [4:0] RUN_NONE     = 5'd0;
	localparam logic [4:0] RUN_ONE      = 5'd1;
	localparam logic [4:0] RUN_TWO      = 5'd2;
	localparam logic [4:0] RUN_BS       = 5'd3;
	localparam logic [4:0] RUN_BS_WRAP  = 5'd4;
	localparam logic [4:0] RUN_INIT     = 5'd10;
	localparam logic [4:0] RUN_GLYPH    = 5'd19;

	typedef enum logic [2:0] {
		OP_CHAR,
		OP_BACKSPACE,
		OP_RETURN,
		OP_SET_POS,
		OP_CLEAR,
		OP_HOME,
		OP_INIT,
		OP_GLYPH
	} tfe_op_t;

	typedef struct packed {
		tfe_op_t     operation;
		logic [7:0]  character_code;
		logic [1:0]  row;
		logic [5:0]  column;
		logic        display;
		logic [2:0]  glyph_index;
		logic [63:0] glyph_rows;
	} tfe_in_t;

	typedef struct packed {
		logic       controller_select;
		logic       register_select;
		logic [7:0] bus_byte;
		logic [1:0] wait_class;
		logic       last_of_run;
	} tfe_wr_t;

	typedef struct packed {
		tfe_op_t     op;
		logic [7:0]  code;
		logic [7:0]  pos;
		logic [1:0]  row;
		logic [5:0]  col;
		logic        disp;
		logic [2:0]  slot;
		logic [63:0] rows;
		logic [4:0]  count;
	} tfe_run_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tfe_q_status_t;

endpackage
`default_nettype wire

>>> src/dual_hd44780_text_front_end.sv
// Top level: text front end for a 40x4 display driven by two HD44780 controllers.
// Each request on cmd is one text operation and becomes a run of 1 to 19 bus
// writes on bus, the final one flagged by last_of_run. The back end emits one
// bus write per clock while bus_stall is low. Writes per operation: a
// character takes 1 or 2, backspace 3 or 4, return 1 or 2, set position,
// clear and home 1, init 10 and a glyph definition 19. The front end takes a
// request every cycle and updates the cursor at once, while the run queue of
// QueueDepth entries has room; character at the end of the display and
// backspace at the start cause no writes and never enter the queue.
`default_nettype none
module dual_hd44780_text_front_end
	import tfe_pkg::*;
#(
	parameter int QueueDepth = TFE_QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	output logic         cmd_stall,
	input  wire tfe_in_t cmd,
	output logic         bus_valid,
	input  wire logic    bus_stall,
	output tfe_wr_t      bus
);

	tfe_q_status_t q_status;
	tfe_run_t      push_run;
	tfe_run_t      head;
	logic          push;
	logic          pop;

	tfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_stall(cmd_stall),
		.q_status (q_status),
		.push     (push),
		.push_run (push_run)
	);

	tfe_queue #(
		.QueueDepth(QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_run(push_run),
		.pop     (pop),
		.status  (q_status),
		.head    (head)
	);

	tfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.head     (head),
		.pop      (pop),
		.bus_valid(bus_valid),
		.bus_stall(bus_stall),
		.bus      (bus)
	);

endmodule
`default_nettype wire

>>> src/tfe_front.sv
// Front end: accepts requests, tracks the cursor and builds run descriptors.
`default_nettype none
module tfe_front
	import tfe_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire tfe_in_t       cmd,
	output logic               cmd_stall,
	input  wire tfe_q_status_t q_status,
	output logic               push,
	output tfe_run_t           push_run
);

	logic [7:0] cursor_q;
	logic [7:0] cursor_d;
	logic [7:0] pos;
	logic [1:0] line;
	logic [5:0] col_sat;
	logic [7:0] row_base;
	logic [4:0] count;
	logic       accept;

	assign cmd_stall = q_status.full;
	assign accept    = cmd_valid && !q_status.full;

	always_comb begin
		col_sat = (cmd.column > LAST_COLUMN) ? LAST_COLUMN : cmd.column;
		unique case (cmd.row)
			2'd0: row_base = 8'd0;
			2'd1: row_base = LINE1_START;
			2'd2: row_base = LINE2_START;
			default: row_base = LINE3_START;
		endcase
		if (cursor_q < LINE1_START) begin
			line = 2'd0;
		end else if (cursor_q < LOWER_START) begin
			line = 2'd1;
		end else if (cursor_q < LINE3_START) begin
			line = 2'd2;
		end else begin
			line = 2'd3;
		end
		pos      = cursor_q;
		cursor_d = cursor_q;
		count    = RUN_ONE;
		unique case (cmd.operation) inside
			OP_CHAR: begin
				if (cursor_q >= CELL_END) begin
					count = RUN_NONE;
				end else begin
					count    = (cursor_q == LAST_UPPER) ? RUN_TWO : RUN_ONE;
					cursor_d = cursor_q + 8'd1;
				end
			end
			OP_BACKSPACE: begin
				pos = cursor_q - 8'd1;
				if (cursor_q == 8'd0) begin
					count = RUN_NONE;
				end else begin
					count    = (cursor_q == LOWER_START) ? RUN_BS_WRAP : RUN_BS;
					cursor_d = cursor_q - 8'd1;
				end
			end
			OP_RETURN: begin
				unique case (line)
					2'd0: begin
						count    = RUN_TWO;
						cursor_d = LINE1_START;
					end
					2'd1: begin
						count    = RUN_TWO;
						cursor_d = LINE2_START;
					end
					2'd2: begin
						count    = RUN_TWO;
						cursor_d = LINE3_START;
					end
					default: count = RUN_ONE;
				endcase
			end
			OP_SET_POS: cursor_d = row_base + {2'b00, col_sat};
			OP_CLEAR, OP_HOME: count = RUN_ONE;
			OP_INIT: begin
				count    = RUN_INIT;
				cursor_d = 8'd0;
			end
			OP_GLYPH: count = RUN_GLYPH;
		endcase
	end

	always_comb begin
		push_run.op    = cmd.operation;
		push_run.code  = cmd.character_code;
		push_run.pos   = pos;
		push_run.row   = cmd.row;
		push_run.col   = col_sat;
		push_run.disp  = cmd.display;
		push_run.slot  = cmd.glyph_index;
		push_run.rows  = cmd.glyph_rows;
		push_run.count = count;
		push           = accept && (count != RUN_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= 8'd0;
		end else if (accept) begin
			cursor_q <= cursor_d;
		end
	end

endmodule
`default_nettype wire

>>> src/tfe_queue.sv
// Queue: short FIFO of run descriptors between the front and back ends.
`default_nettype none
module tfe_queue
	import tfe_pkg::*;
#(
	parameter int QueueDepth = TFE_QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire tfe_run_t push_run,
	input  wire logic     pop,
	output tfe_q_status_t status,
	output tfe_run_t      head
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

	tfe_run_t        entry_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fill_q;
	logic            do_push;
	logic            do_pop;

	assign status.full  = (fill_q == CntFull);
	assign status.empty = (fill_q == '0);
	assign head         = entry_q[rd_ptr_q];
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> src/tfe_back.sv
// Back end: steps through each run and emits one bus write per cycle while bus_stall is low.
`default_nettype none
module tfe_back
	import tfe_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tfe_q_status_t q_status,
	input  wire tfe_run_t      head,
	output logic               pop,
	output logic               bus_valid,
	input  wire logic          bus_stall,
	output tfe_wr_t            bus
);

	logic [4:0] step_q;
	logic       bus_valid_q;
	tfe_wr_t    bus_q;
	tfe_wr_t    wr;
	logic       head_valid;
	logic       load;
	logic       last;
	logic [3:0] glyph_step;
	logic [2:0] init_step;
	logic [1:0] cell_line;

	function automatic tfe_wr_t cell_write(input logic [7:0] pos);
		tfe_wr_t    w;
		logic [7:0] addr;
		w.register_select = RS_CMD;
		w.wait_class      = WAIT_SHORT;
		w.last_of_run     = 1'b0;
		if (pos < LINE1_START) begin
			w.controller_select = 1'b0;
			addr                = pos;
		end else if (pos < LOWER_START) begin
			w.controller_select = 1'b0;
			addr                = pos + LINE1_OFFS;
		end else if (pos < LINE3_START) begin
			w.controller_select = 1'b1;
			addr                = pos - LINE2_OFFS;
		end else begin
			w.controller_select = 1'b1;
			addr                = pos - LINE3_OFFS;
		end
		w.bus_byte = addr | CMD_SET_DDRAM;
		return w;
	endfunction

	assign head_valid = !q_status.empty;
	assign load       = !bus_valid_q || !bus_stall;
	assign last       = (step_q == head.count - 5'd1);
	assign pop        = load && head_valid && last;
	assign glyph_step = 4'(step_q - 5'd2);
	assign init_step  = (step_q < 5'd5) ? step_q[2:0] : 3'(step_q - 5'd5);

	always_comb begin
		if (head.pos < LINE1_START) begin
			cell_line = 2'd0;
		end else if (head.pos < LOWER_START) begin
			cell_line = 2'd1;
		end else if (head.pos < LINE3_START) begin
			cell_line = 2'd2;
		end else begin
			cell_line = 2'd3;
		end
		wr                   = cell_write(head.pos);
		unique case (head.op) inside
			OP_CHAR: begin
				if (step_q == 5'd0) begin
					wr.controller_select = (head.pos >= LOWER_START);
					wr.register_select   = RS_DATA;
					wr.bus_byte          = head.code;
					wr.wait_class        = WAIT_DATA;
				end else begin
					wr.controller_select = 1'b1;
					wr.bus_byte          = CMD_SET_DDRAM;
				end
			end
			OP_BACKSPACE: begin
				if (step_q == 5'd1) begin
					wr.controller_select = (head.pos >= LOWER_START);
					wr.register_select   = RS_DATA;
					wr.bus_byte          = CHAR_SPACE;
					wr.wait_class        = WAIT_DATA;
				end else if (step_q == 5'd2 && !last) begin
					wr.controller_select = 1'b1;
					wr.bus_byte          = CMD_SET_DDRAM;
				end
			end
			OP_RETURN: begin
				if (step_q != 5'd0) begin
					wr.controller_select = (cell_line != 2'd0);
					wr.bus_byte = cell_line[0] ? CMD_SET_DDRAM : CMD_LINE_ODD;
				end
			end
			OP_SET_POS: begin
				wr.controller_select = head.row[1];
				wr.bus_byte          = {1'b1, head.row[0], head.col};
			end
			OP_CLEAR, OP_HOME: begin
				wr.controller_select = head.disp;
				wr.bus_byte   = (head.op == OP_CLEAR) ? CMD_CLEAR : CMD_HOME;
				wr.wait_class = WAIT_LONG;
			end
			OP_INIT: begin
				wr.controller_select = (step_q >= 5'd5);
				case (init_step) inside
					3'd0, 3'd1: wr.bus_byte = CMD_FUNCTION;
					3'd2: wr.bus_byte = CMD_DISPLAY_ON;
					3'd3: begin
						wr.bus_byte   = CMD_CLEAR;
						wr.wait_class = WAIT_LONG;
					end
					default: begin
						wr.bus_byte   = CMD_HOME;
						wr.wait_class = WAIT_LONG;
					end
				endcase
			end
			OP_GLYPH: begin
				if (step_q < 5'd2) begin
					wr.controller_select = step_q[0];
					wr.bus_byte          = {2'b01, head.slot, 3'b000};
				end else if (step_q < 5'd18) begin
					wr.controller_select = glyph_step[0];
					wr.register_select   = RS_DATA;
					wr.bus_byte          = head.rows[glyph_step[3:1]*8 +: 8];
					wr.wait_class        = WAIT_DATA;
				end
			end
		endcase
		wr.last_of_run = last;
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			bus_q <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_valid_q <= 1'b0;
			step_q      <= 5'd0;
		end else if (load) begin
			bus_valid_q <= head_valid;
			if (head_valid) begin
				step_q <= last ? 5'd0 : step_q + 5'd1;
			end
		end
	end

	assign bus_valid = bus_valid_q;
	assign bus       = bus_q;

endmodule
`default_nettype wire

>>> src/tfe_checker.sv
// Checker: port-level assertions for the text front end, bound to the top level.
`default_nettype none
module tfe_checker
	import tfe_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    cmd_valid,
	input wire logic    cmd_stall,
	input wire tfe_in_t cmd,
	input wire logic    bus_valid,
	input wire logic    bus_stall,
	input wire tfe_wr_t bus
);

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("request changed while stalled");

	a_bus_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		bus_valid && bus_stall |=> bus_valid)
		else $error("bus write dropped while stalled");

	a_bus_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		bus_valid && bus_stall |=> $stable(bus))
		else $error("bus write changed while stalled");

	a_data_wait: assert property (@(posedge clk) disable iff (!arst_n)
		bus_valid |-> ((bus.register_select == RS_DATA) == (bus.wait_class == WAIT_DATA)))
		else $error("register select and wait class disagree");

	a_wait_code: assert property (@(posedge clk) disable iff (!arst_n)
		bus_valid |-> (bus.wait_class != 2'd3))
		else $error("undefined wait class");

endmodule

bind dual_hd44780_text_front_end tfe_checker u_tfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd      (cmd),
	.bus_valid(bus_valid),
	.bus_stall(bus_stall),
	.bus      (bus)
);
`default_nettype wire

>>> dv/tb_top.sv
// Testbench of the dual HD44780 text front end with a predictor of the bus writes.
`timescale 1ns / 1ps

module tb_top;
	import tfe_pkg::*;

	localparam int RANDOM_ITEMS = 155;
	localparam int CALM_TAIL = 25;
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [7:0] ODD_LINE_ADDR = 8'h40;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cmd_valid = 1'b0;
	logic    cmd_stall;
	tfe_in_t cmd = '0;
	logic    bus_valid;
	logic    bus_stall = 1'b0;
	tfe_wr_t bus;

	tfe_in_t pending[$];
	tfe_wr_t expected_writes[$];
	logic [7:0] cursor_cell = 8'd0;

	bit calm = 1'b0;
	bit timed_out = 1'b0;
	bit held_once = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int writes_seen = 0;
	int mismatches = 0;

	dual_hd44780_text_front_end DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.bus_valid(bus_valid),
		.bus_stall(bus_stall),
		.bus(bus)
	);

	always #2 clk = ~clk;

	function automatic void emit_write(logic ctrl, logic rs, logic [7:0] data, logic [1:0] settle);
		tfe_wr_t w;
		w.controller_select = ctrl;
		w.register_select = rs;
		w.bus_byte = data;
		w.wait_class = settle;
		w.last_of_run = 1'b0;
		expected_writes.push_back(w);
	endfunction

	function automatic void emit_address(logic ctrl, logic [7:0] addr);
		emit_write(ctrl, RS_CMD, addr | CMD_SET_DDRAM, WAIT_SHORT);
	endfunction

	function automatic logic [1:0] address_cell(logic [7:0] pos);
		if (pos < LOWER_START) begin
			if (pos < LINE1_START) begin
				emit_address(1'b0, pos);
				return 2'd0;
			end
			emit_address(1'b0, pos + LINE1_OFFS);
			return 2'd1;
		end
		if (pos < LINE3_START) begin
			emit_address(1'b1, pos - LINE2_OFFS);
			return 2'd2;
		end
		emit_address(1'b1, pos - LINE3_OFFS);
		return 2'd3;
	endfunction

	function automatic void emit_char(logic [7:0] code);
		if (cursor_cell >= CELL_END)
			return;
		emit_write(cursor_cell >= LOWER_START, RS_DATA, code, WAIT_DATA);
		cursor_cell = cursor_cell + 8'd1;
		if (cursor_cell == LOWER_START)
			emit_address(1'b1, 8'd0);
	endfunction

	function automatic void emit_init(logic ctrl);
		emit_write(ctrl, RS_CMD, CMD_FUNCTION, WAIT_SHORT);
		emit_write(ctrl, RS_CMD, CMD_FUNCTION, WAIT_SHORT);
		emit_write(ctrl, RS_CMD, CMD_DISPLAY_ON, WAIT_SHORT);
		emit_write(ctrl, RS_CMD, CMD_CLEAR, WAIT_LONG);
		emit_write(ctrl, RS_CMD, CMD_HOME, WAIT_LONG);
	endfunction

	function automatic void plan_writes(tfe_in_t req);
		int before_len;
		int i;
		logic [1:0] line;
		logic [5:0] col;
		logic [7:0] slot_cmd;
		tfe_wr_t w;
		before_len = expected_writes.size();
		if (cursor_cell > CELL_END)
			cursor_cell = CELL_END;
		case (req.operation)
			OP_CHAR: emit_char(req.character_code);
			OP_BACKSPACE: begin
				if (cursor_cell != 8'd0) begin
					cursor_cell = cursor_cell - 8'd1;
					void'(address_cell(cursor_cell));
					emit_char(CHAR_SPACE);
					cursor_cell = cursor_cell - 8'd1;
					void'(address_cell(cursor_cell));
				end
			end
			OP_RETURN: begin
				line = address_cell(cursor_cell);
				if (line != 2'd3) begin
					line = line + 2'd1;
					emit_address(line[1], line[0] ? ODD_LINE_ADDR : 8'h00);
					cursor_cell = line * LINE1_START;
				end
			end
			OP_SET_POS: begin
				col = (req.column > LAST_COLUMN) ? LAST_COLUMN : req.column;
				emit_address(req.row[1], (req.row[0] ? ODD_LINE_ADDR : 8'h00) + col);
				cursor_cell = req.row * LINE1_START + col;
			end
			OP_CLEAR: emit_write(req.display, RS_CMD, CMD_CLEAR, WAIT_LONG);
			OP_HOME: emit_write(req.display, RS_CMD, CMD_HOME, WAIT_LONG);
			OP_INIT: begin
				cursor_cell = 8'd0;
				emit_init(1'b0);
				emit_init(1'b1);
			end
			OP_GLYPH: begin
				slot_cmd = CMD_SET_CGRAM | {2'b00, req.glyph_index, 3'b000};
				emit_write(1'b0, RS_CMD, slot_cmd, WAIT_SHORT);
				emit_write(1'b1, RS_CMD, slot_cmd, WAIT_SHORT);
				for (i = 0; i < 8; i++) begin
					emit_write(1'b0, RS_DATA, req.glyph_rows[i*8 +: 8], WAIT_DATA);
					emit_write(1'b1, RS_DATA, req.glyph_rows[i*8 +: 8], WAIT_DATA);
				end
				void'(address_cell(cursor_cell));
			end
			default: ;
		endcase
		if (expected_writes.size() > before_len) begin
			w = expected_writes.pop_back();
			w.last_of_run = 1'b1;
			expected_writes.push_back(w);
		end
	endfunction

	function automatic void check_write(tfe_wr_t got);
		tfe_wr_t want;
		writes_seen++;
		if (expected_writes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected bus write ctrl %0d rs %0d byte %h wait %0d last %0d",
					$realtime, got.controller_select, got.register_select, got.bus_byte,
					got.wait_class, got.last_of_run);
			return;
		end
		want = expected_writes.pop_front();
		if (got.controller_select !== want.controller_select ||
				got.register_select !== want.register_select ||
				got.bus_byte !== want.bus_byte ||
				got.wait_class !== want.wait_class ||
				got.last_of_run !== want.last_of_run) begin
			mismatches++;
			if (mismatches <= 10) begin
				$write("%0t: bus write %0d expected ctrl %0d rs %0d byte %h wait %0d last %0d,",
					$realtime, writes_seen, want.controller_select, want.register_select,
					want.bus_byte, want.wait_class, want.last_of_run);
				$display(" got ctrl %0d rs %0d byte %h wait %0d last %0d",
					got.controller_select, got.register_select, got.bus_byte,
					got.wait_class, got.last_of_run);
			end
		end
	endfunction

	function automatic tfe_in_t random_request(tfe_op_t op);
		tfe_in_t r;
		r.operation = op;
		r.character_code = 8'($urandom);
		r.row = 2'($urandom);
		r.column = 6'($urandom);
		r.display = 1'($urandom);
		r.glyph_index = 3'($urandom);
		r.glyph_rows = {$urandom, $urandom};
		return r;
	endfunction

	function automatic tfe_in_t position_request(logic [1:0] row, logic [5:0] col);
		tfe_in_t r;
		r = random_request(OP_SET_POS);
		r.row = row;
		r.column = col;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				plan_writes(cmd);
			if (!cmd_valid || !cmd_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (pending.size() != 0 && !calm && $urandom_range(0, 4) == 0) begin
					send_gap = $urandom_range(0, 2);
					cmd_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					cmd <= pending.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			calm <= pending.size() < CALM_TAIL;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (bus_valid && !bus_stall)
				check_write(bus);
			if (hold_left > 0) begin
				hold_left--;
				bus_stall <= 1'b1;
			end else if (!held_once && writes_seen >= 60) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				bus_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				bus_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				recv_gap = $urandom_range(0, 2);
				bus_stall <= 1'b1;
			end else begin
				bus_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (bus_valid && !bus_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT)
				timed_out <= 1'b1;
		end
	end

	initial begin
		tfe_in_t r;
		int pick;
		int directed_count;
		logic [5:0] col;

		pending.push_back(random_request(OP_INIT));
		r = random_request(OP_CHAR);
		r.character_code = 8'h00;
		pending.push_back(r);
		r = random_request(OP_CHAR);
		r.character_code = 8'hFF;
		pending.push_back(r);
		pending.push_back(position_request(2'd0, 6'd0));
		pending.push_back(random_request(OP_BACKSPACE));
		pending.push_back(position_request(2'd1, 6'd39));
		pending.push_back(random_request(OP_CHAR));
		pending.push_back(random_request(OP_BACKSPACE));
		pending.push_back(position_request(2'd1, 6'd63));
		pending.push_back(random_request(OP_RETURN));
		pending.push_back(random_request(OP_RETURN));
		pending.push_back(random_request(OP_RETURN));
		pending.push_back(position_request(2'd3, 6'd39));
		pending.push_back(random_request(OP_CHAR));
		pending.push_back(random_request(OP_CHAR));
		pending.push_back(random_request(OP_BACKSPACE));
		pending.push_back(random_request(OP_RETURN));
		pending.push_back(position_request(2'd0, 6'd5));
		pending.push_back(random_request(OP_RETURN));
		r = random_request(OP_CLEAR);
		r.display = 1'b0;
		pending.push_back(r);
		r = random_request(OP_CLEAR);
		r.display = 1'b1;
		pending.push_back(r);
		r = random_request(OP_HOME);
		r.display = 1'b0;
		pending.push_back(r);
		r = random_request(OP_HOME);
		r.display = 1'b1;
		pending.push_back(r);
		r = random_request(OP_GLYPH);
		r.glyph_index = 3'd7;
		r.glyph_rows = '1;
		pending.push_back(r);
		r = random_request(OP_GLYPH);
		r.glyph_index = 3'd0;
		r.glyph_rows = '0;
		pending.push_back(r);
		directed_count = pending.size();

		// In half of the picks a position near a line end followed by typing, so that the cursor
		// crosses the controller boundary and runs into the end of the display.
		while (pending.size() < directed_count + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				col = ($urandom_range(0, 2) != 0) ? 6'($urandom_range(30, 39)) : 6'($urandom);
				pending.push_back(position_request(2'($urandom), col));
				repeat ($urandom_range(1, 12)) begin
					if ($urandom_range(0, 5) == 0)
						pending.push_back(random_request(OP_BACKSPACE));
					else if ($urandom_range(0, 9) == 0)
						pending.push_back(random_request(OP_RETURN));
					else
						pending.push_back(random_request(OP_CHAR));
				end
			end else if (pick < 7) begin
				pending.push_back(random_request(OP_CHAR));
			end else begin
				pending.push_back(random_request(tfe_op_t'($urandom_range(0, 7))));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (pending.size() != 0 || cmd_valid || expected_writes.size() != 0))
			@(posedge clk);
		if (!timed_out)
			repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_writes.size() != 0)
			$display("%0d expected bus writes never arrived", expected_writes.size());
		if (!timed_out && mismatches == 0 && expected_writes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
src/tfe_pkg.sv
src/tfe_front.sv
src/tfe_queue.sv
src/tfe_back.sv
src/dual_hd44780_text_front_end.sv
src/tfe_checker.sv
dv/tb_top.sv
